### hw/rtl/grs_pkg.sv
// Shared types and constants for the graph reachability search block.
// No dependencies; used by grs_search and graph_reachability_search.
package grs_pkg;

  localparam int unsigned OpcodeWidth  = 2;
  localparam int unsigned VtxWidth     = 4;
  localparam int unsigned VcountWidth  = 5;
  localparam logic [VcountWidth-1:0] VcountReset = 5'd16;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_BFS      = 2'd2,
    OP_DFS      = 2'd3
  } op_e;

  typedef struct packed {
    logic                found;
    logic [VtxWidth-1:0] path_vertex;
    logic                last;
  } result_t;

endpackage

### hw/rtl/grs_adj_mem.sv
// Adjacency row memory: one row per vertex, synchronous read, one write port.
// Row valid flops let a clear empty every row at once. Depends on no package.
module grs_adj_mem #(
  parameter int unsigned MaxVertices = 16,
  parameter int unsigned VW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VW-1:0]          rd_addr_i,
  output logic [MaxVertices-1:0] rd_data_o,
  input  logic                   wr_en_i,
  input  logic [VW-1:0]          wr_addr_i,
  input  logic [MaxVertices-1:0] wr_data_i,
  input  logic                   clr_i
);

  logic [MaxVertices-1:0] mem [MaxVertices];
  logic [MaxVertices-1:0] row_valid_q;
  logic [MaxVertices-1:0] rd_data_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      rd_valid_q <= row_valid_q[rd_addr_i];
      if (clr_i) begin
        row_valid_q <= '0;
      end else if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // A row never written since reset or clear reads as empty.
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

### hw/rtl/grs_search.sv
// Command sequencer and search engine: visited marks, work list memory,
// predecessor memory and path trace. Depends on grs_pkg and grs_adj_mem ports.
module grs_search #(
  parameter int unsigned MaxVertices = 16,
  parameter int unsigned VW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1,
  parameter int unsigned PW = $clog2(MaxVertices + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  grs_pkg::op_e                      opcode_i,
  input  logic [grs_pkg::VtxWidth-1:0]      src_i,
  input  logic [grs_pkg::VtxWidth-1:0]      dst_i,
  input  logic [grs_pkg::VcountWidth-1:0]   vcount_i,
  output logic                              busy_o,
  input  logic                              out_free_i,
  output logic                              emit_valid_o,
  output grs_pkg::result_t                  emit_o,
  output logic [VW-1:0]                     adj_rd_addr_o,
  input  logic [MaxVertices-1:0]            adj_rd_data_i,
  output logic                              adj_wr_en_o,
  output logic [VW-1:0]                     adj_wr_addr_o,
  output logic [MaxVertices-1:0]            adj_wr_data_o,
  output logic                              adj_clr_o
);
  import grs_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_ADD_RD = 11'b000_0000_0010,
    ST_ADD_WR = 11'b000_0000_0100,
    ST_START  = 11'b000_0000_1000,
    ST_FETCH  = 11'b000_0001_0000,
    ST_ADDR   = 11'b000_0010_0000,
    ST_LOAD   = 11'b000_0100_0000,
    ST_SCAN   = 11'b000_1000_0000,
    ST_EMIT   = 11'b001_0000_0000,
    ST_PRED   = 11'b010_0000_0000,
    ST_RESP   = 11'b100_0000_0000
  } state_e;

  localparam int unsigned NW = $clog2(MaxVertices + 1);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [VW-1:0] s_q, s_d, g_q, g_d, cur_q, cur_d, v_q, v_d;
  logic [MaxVertices-1:0] nmask_q, nmask_d, vis_q, vis_d, row_q, row_d;
  logic [PW-1:0] head_q, head_d, ptr_q, ptr_d;
  logic resp_found_q, resp_found_d;

  logic [VW-1:0] wl_mem [MaxVertices];
  logic [VW-1:0] pred_mem [MaxVertices];
  logic [VW-1:0] wl_rdata_q, pred_rdata_q;
  logic          wl_we, pred_we;
  logic [VW-1:0] wl_waddr, wl_wdata, wl_raddr, pred_waddr, pred_wdata, pred_raddr;

  logic [NW-1:0]          n_act;
  logic [MaxVertices-1:0] nmask_in;
  logic                   out_of_range;
  logic [MaxVertices-1:0] cand;
  logic [VW-1:0]          low_u;
  logic [PW-1:0]          ptr_m1;

  function automatic logic [VW-1:0] lowest_set(input logic [MaxVertices-1:0] c);
    logic [VW-1:0] idx;
    idx = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (c[i]) idx = VW'(i);
    end
    return idx;
  endfunction

  // Clamp the vertex count into 1..MaxVertices.
  always_comb begin
    if (vcount_i == '0) begin
      n_act = NW'(1);
    end else if (int'(vcount_i) > int'(MaxVertices)) begin
      n_act = NW'(MaxVertices);
    end else begin
      n_act = NW'(vcount_i);
    end
    for (int i = 0; i < int'(MaxVertices); i++) begin
      nmask_in[i] = (i < int'(n_act));
    end
    out_of_range = (int'(src_i) >= int'(n_act)) || (int'(dst_i) >= int'(n_act));
  end

  assign cand   = row_q & ~vis_q & nmask_q;
  assign low_u  = lowest_set(cand);
  assign ptr_m1 = PW'(ptr_q - PW'(1));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    s_d          = s_q;
    g_d          = g_q;
    cur_d        = cur_q;
    v_d          = v_q;
    nmask_d      = nmask_q;
    vis_d        = vis_q;
    row_d        = row_q;
    head_d       = head_q;
    ptr_d        = ptr_q;
    resp_found_d = resp_found_q;
    wl_we        = 1'b0;
    wl_waddr     = ptr_q[VW-1:0];
    wl_wdata     = low_u;
    wl_raddr     = head_q[VW-1:0];
    pred_we      = 1'b0;
    pred_waddr   = low_u;
    pred_wdata   = cur_q;
    pred_raddr   = v_q;
    adj_rd_addr_o = s_q;
    adj_wr_en_o   = 1'b0;
    adj_wr_addr_o = s_q;
    adj_wr_data_o = adj_rd_data_i | (MaxVertices'(1) << g_q);
    adj_clr_o     = 1'b0;
    emit_valid_o  = 1'b0;
    emit_o        = '{found: resp_found_q, path_vertex: '0, last: 1'b1};

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = opcode_i;
          s_d     = VW'(src_i);
          g_d     = VW'(dst_i);
          nmask_d = nmask_in;
          case (opcode_i)
            OP_ADD_EDGE: begin
              resp_found_d = !out_of_range;
              state_d      = out_of_range ? ST_RESP : ST_ADD_RD;
            end
            OP_CLEAR: begin
              adj_clr_o    = 1'b1;
              resp_found_d = 1'b1;
              state_d      = ST_RESP;
            end
            default: begin
              resp_found_d = 1'b0;
              if (out_of_range) begin
                state_d = ST_RESP;
              end else if (src_i == dst_i) begin
                v_d     = VW'(src_i);
                state_d = ST_EMIT;
              end else begin
                state_d = ST_START;
              end
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        adj_wr_en_o = 1'b1;
        state_d     = ST_RESP;
      end
      ST_START: begin
        vis_d    = MaxVertices'(1) << s_q;
        wl_we    = 1'b1;
        wl_waddr = '0;
        wl_wdata = s_q;
        head_d   = '0;
        ptr_d    = PW'(1);
        state_d  = ST_FETCH;
      end
      ST_FETCH: begin
        if (op_q == OP_DFS) begin
          wl_raddr = ptr_m1[VW-1:0];
          state_d  = (ptr_q == '0) ? ST_RESP : ST_ADDR;
        end else begin
          if (head_q == ptr_q) begin
            state_d = ST_RESP;
          end else begin
            head_d  = PW'(head_q + PW'(1));
            state_d = ST_ADDR;
          end
        end
      end
      ST_ADDR: begin
        cur_d         = wl_rdata_q;
        adj_rd_addr_o = wl_rdata_q;
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        row_d   = adj_rd_data_i;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (op_q == OP_DFS) begin
          if (cand == '0) begin
            ptr_d   = ptr_m1;
            state_d = ST_FETCH;
          end else begin
            pred_we = 1'b1;
            if (low_u == g_q) begin
              v_d     = g_q;
              state_d = ST_EMIT;
            end else begin
              vis_d[low_u] = 1'b1;
              wl_we        = 1'b1;
              ptr_d        = PW'(ptr_q + PW'(1));
              state_d      = ST_FETCH;
            end
          end
        end else begin
          if (cand[g_q]) begin
            pred_we    = 1'b1;
            pred_waddr = g_q;
            v_d        = g_q;
            state_d    = ST_EMIT;
          end else if (cand == '0) begin
            state_d = ST_FETCH;
          end else begin
            // Take one new neighbor per cycle, lowest index first.
            vis_d[low_u] = 1'b1;
            pred_we      = 1'b1;
            wl_we        = 1'b1;
            ptr_d        = PW'(ptr_q + PW'(1));
          end
        end
      end
      ST_EMIT: begin
        emit_valid_o = 1'b1;
        emit_o       = '{found: 1'b1, path_vertex: VtxWidth'(v_q), last: (v_q == s_q)};
        if (out_free_i) begin
          state_d = (v_q == s_q) ? ST_IDLE : ST_PRED;
        end
      end
      ST_PRED: begin
        v_d     = pred_rdata_q;
        state_d = ST_EMIT;
      end
      ST_RESP: begin
        emit_valid_o = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (wl_we) begin
      wl_mem[wl_waddr] <= wl_wdata;
    end
    if (pred_we) begin
      pred_mem[pred_waddr] <= pred_wdata;
    end
    wl_rdata_q   <= wl_mem[wl_raddr];
    pred_rdata_q <= pred_mem[pred_raddr];
    op_q    <= op_d;
    s_q     <= s_d;
    g_q     <= g_d;
    cur_q   <= cur_d;
    v_q     <= v_d;
    nmask_q <= nmask_d;
    row_q   <= row_d;
    resp_found_q <= resp_found_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vis_q   <= '0;
      head_q  <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      vis_q   <= vis_d;
      head_q  <= head_d;
      ptr_q   <= ptr_d;
    end
  end

  a_bfs_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && op_q == OP_BFS) |-> (head_q <= ptr_q))
    else $error("work list head passed tail");

  a_start_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> vis_q[s_q])
    else $error("start vertex lost its visited mark");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (int'(ptr_q) <= int'(MaxVertices)))
    else $error("work list overflow");

  a_emit_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && out_free_i && emit_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the final result");

endmodule

### hw/rtl/graph_reachability_search.sv
// Top level of the graph reachability search block.
// Depends on grs_pkg, grs_adj_mem and grs_search.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command item:
//   add edge, clear graph, breadth-first query or depth-first query.
//   Output channel (out_valid_o / out_stall_i) carries result items;
//   last_o marks the final result of a command. A found query returns the
//   path from goal back to start, one vertex per item.
//   The block takes one command at a time; in_stall_o stays high until the
//   final result of the current command has entered the output register.
//   Clear responds directly; add edge reads the source row and writes it
//   back with the goal bit set before it responds. A query takes each vertex
//   off the work list (list read, adjacency row read, scan), pushes each new
//   neighbor in turn, then traces the path back through the predecessors.
//   Reset: empty graph, vertex_count = 16, both channels idle.
//   A stalled receiver holds the output register; the sequencer waits.
//   cfg_we_i writes vertex_count; write it only while the block is idle.
module graph_reachability_search #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [grs_pkg::VcountWidth-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  grs_pkg::op_e                    opcode_i,
  input  logic [grs_pkg::VtxWidth-1:0]    src_vertex_i,
  input  logic [grs_pkg::VtxWidth-1:0]    dst_vertex_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [grs_pkg::VtxWidth-1:0]    path_vertex_o,
  output logic                            last_o
);
  import grs_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic [VcountWidth-1:0] vcount_q;
  logic                   busy, start, out_free, emit_valid;
  result_t                emit, out_q;
  logic                   out_valid_q;
  logic [VW-1:0]          adj_rd_addr, adj_wr_addr;
  logic [MAX_VERTICES-1:0] adj_rd_data, adj_wr_data;
  logic                   adj_wr_en, adj_clr;

  // Config register keeps the bits written; the engine clamps them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VcountReset;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  assign start    = in_valid_i && !busy;
  assign out_free = !out_valid_q || !out_stall_i;

  grs_adj_mem #(.MaxVertices(MAX_VERTICES)) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (adj_rd_addr),
    .rd_data_o (adj_rd_data),
    .wr_en_i   (adj_wr_en),
    .wr_addr_i (adj_wr_addr),
    .wr_data_i (adj_wr_data),
    .clr_i     (adj_clr)
  );

  grs_search #(.MaxVertices(MAX_VERTICES)) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .opcode_i      (opcode_i),
    .src_i         (src_vertex_i),
    .dst_i         (dst_vertex_i),
    .vcount_i      (vcount_q),
    .busy_o        (busy),
    .out_free_i    (out_free),
    .emit_valid_o  (emit_valid),
    .emit_o        (emit),
    .adj_rd_addr_o (adj_rd_addr),
    .adj_rd_data_i (adj_rd_data),
    .adj_wr_en_o   (adj_wr_en),
    .adj_wr_addr_o (adj_wr_addr),
    .adj_wr_data_o (adj_wr_data),
    .adj_clr_o     (adj_clr)
  );

  // Output register: load a new item when empty or being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && out_free) begin
      out_q <= emit;
    end
  end

  assign in_stall_o    = busy;
  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign path_vertex_o = out_q.path_vertex;
  assign last_o        = out_q.last;

endmodule
